@@ rtl/core/dual_stepper_pulse_generator_assert.svh @@
// ----------------------------------------------------------------------------
// dual stepper pulse generator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DUAL_STEPPER_PULSE_GENERATOR_ASSERT_SVH
`define DUAL_STEPPER_PULSE_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define DSP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dsp port check failed");

// next-cycle implication, off during reset
`define DSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dsp port check failed");

// next-cycle implication, also active in reset
`define DSP_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dsp port check failed");

`endif

@@ rtl/core/dsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dsp_pkg
// types and constants shared by the dual stepper pulse generator
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_REL    = 3'd1;
    localparam logic [2:0] CMD_VEL    = 3'd2;
    localparam logic [2:0] CMD_ABS    = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;
    localparam logic [2:0] CMD_ENABLE = 3'd5;

    localparam logic [1:0] MODE_COUNT  = 2'd0;
    localparam logic [1:0] MODE_VEL    = 2'd1;
    localparam logic [1:0] MODE_TARGET = 2'd2;

    localparam logic [2:0] REG_HOLD  = 3'd0;
    localparam logic [2:0] REG_MIN   = 3'd1;
    localparam logic [2:0] REG_MAX   = 3'd2;
    localparam logic [2:0] REG_START = 3'd3;
    localparam logic [2:0] REG_RAMP  = 3'd4;

    localparam logic [14:0] HP_NUMERATOR = 15'd10000;
    localparam logic [7:0]  HP_SAT       = 8'd255;
    localparam logic [3:0]  DIV_LAST     = 4'd14;

    typedef struct packed {
        logic        hold;
        logic [11:0] min_rate;
        logic [11:0] max_rate;
        logic [11:0] start_rate;
        logic [3:0]  ramp_interval;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hold: 1'b1, min_rate: 12'd20, max_rate: 12'd4000,
        start_rate: 12'd300, ramp_interval: 4'd8
    };

    typedef struct packed {
        logic [31:0] position;
        logic        dir_pos;
        logic        moving;
        logic        step_level;
        logic [32:0] toggles_left;
        logic [1:0]  mode;
        logic        vel_pos;
        logic [31:0] goal_position;
        logic [7:0]  cur_hp;
        logic [7:0]  goal_hp;
        logic [7:0]  ticks;
        logic [3:0]  ramp_ticks;
        logic        drv_en;
    } axis_state_t;

    localparam axis_state_t AXIS_RESET = '{
        position: 32'd0, dir_pos: 1'b1, moving: 1'b0, step_level: 1'b0,
        toggles_left: 33'd0, mode: MODE_COUNT, vel_pos: 1'b1,
        goal_position: 32'd0, cur_hp: 8'd1, goal_hp: 8'd1, ticks: 8'd0,
        ramp_ticks: 4'd0, drv_en: 1'b1
    };

    typedef struct packed {
        logic        step;
        logic        dir;
        logic        en;
        logic        busy;
        logic [31:0] position;
    } axis_view_t;

    localparam axis_view_t VIEW_RESET = '{
        step: 1'b0, dir: 1'b1, en: 1'b1, busy: 1'b0, position: 32'd0
    };

endpackage

@@ rtl/core/dsp_state_ram.sv @@
// ----------------------------------------------------------------------------
// dsp_state_ram
// per-axis state memory, one entry per axis, registered read
// ----------------------------------------------------------------------------
module dsp_state_ram (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic                 rd_addr,
    output dsp_pkg::axis_state_t rd_data,
    input  logic                 wr_en,
    input  logic                 wr_addr,
    input  dsp_pkg::axis_state_t wr_data
);
    import dsp_pkg::*;

    axis_state_t mem [2];
    logic [1:0]  valid_reg;
    axis_state_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : AXIS_RESET;
        end
    end

    // unwritten entries read as the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 2'b00;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/dsp_half_period.sv @@
// ----------------------------------------------------------------------------
// dsp_half_period
// rate clamp and serial divider for ceil(10000 / (2 * hz)) half periods
// ----------------------------------------------------------------------------
module dsp_half_period (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   hz,
    input  logic          twice,
    input  dsp_pkg::cfg_t cfg,
    output logic          done,
    output logic [7:0]    hp
);
    import dsp_pkg::*;

    logic [31:0] min_w;
    logic [31:0] max_w;
    logic [31:0] c1;
    logic [31:0] c2;
    logic        busy_reg;
    logic        done_reg;
    logic        zero_reg;
    logic [3:0]  cnt_reg;
    logic [14:0] num_reg;
    logic [12:0] den_reg;
    logic [12:0] rem_reg;
    logic [14:0] quo_reg;
    logic [7:0]  hp_reg;
    logic [13:0] shifted;
    logic [12:0] rem_next;
    logic [14:0] quo_next;
    logic [7:0]  hp_next;

    assign min_w = {20'd0, cfg.min_rate};
    assign max_w = {20'd0, cfg.max_rate};

    always_comb begin
        priority if (hz < min_w) begin
            c1 = min_w;
        end else if (hz > max_w) begin
            c1 = max_w;
        end else begin
            c1 = hz;
        end
        c2 = c1;
        if (twice) begin
            priority if (c1 < min_w) begin
                c2 = min_w;
            end else if (c1 > max_w) begin
                c2 = max_w;
            end else begin
                c2 = c1;
            end
        end
    end

    // one restoring step per cycle
    always_comb begin
        shifted = {rem_reg, num_reg[14]};
        if (shifted >= {1'b0, den_reg}) begin
            rem_next = 13'(shifted - {1'b0, den_reg});
            quo_next = {quo_reg[13:0], 1'b1};
        end else begin
            rem_next = shifted[12:0];
            quo_next = {quo_reg[13:0], 1'b0};
        end
        priority if (zero_reg) begin
            hp_next = HP_SAT;
        end else if (quo_next > 15'd255) begin
            hp_next = HP_SAT;
        end else if (quo_next == 15'd0) begin
            hp_next = 8'd1;
        end else begin
            hp_next = quo_next[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                num_reg <= {num_reg[13:0], 1'b0};
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    hp_reg   <= hp_next;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_LAST;
                rem_reg  <= 13'd0;
                quo_reg  <= 15'd0;
                zero_reg <= (c2 == 32'd0);
                den_reg  <= {c2[11:0], 1'b0};
                num_reg  <= 15'(HP_NUMERATOR + {2'b00, c2[11:0], 1'b0} - 15'd1);
            end
        end
    end

    assign done = done_reg;
    assign hp   = hp_reg;

endmodule

@@ rtl/core/dsp_axis_update.sv @@
// ----------------------------------------------------------------------------
// dsp_axis_update
// next state of one axis for a command or a tick
// ----------------------------------------------------------------------------
module dsp_axis_update (
    input  logic [2:0]           cmd,
    input  logic [31:0]          amount,
    input  dsp_pkg::cfg_t        cfg,
    input  logic [7:0]           hp_goal,
    input  logic [7:0]           hp_start,
    input  dsp_pkg::axis_state_t cur,
    output dsp_pkg::axis_state_t nxt,
    output logic                 acc
);
    import dsp_pkg::*;

    logic [31:0] mag;
    logic        vel_start;
    logic        abs_start;
    logic        abs_pos;
    axis_state_t upd;

    function automatic axis_state_t f_stop(input axis_state_t x, input logic hold);
        axis_state_t y;
        y              = x;
        y.toggles_left = 33'd0;
        y.step_level   = 1'b0;
        y.mode         = MODE_COUNT;
        y.moving       = 1'b0;
        y.ramp_ticks   = 4'd0;
        if (!hold) begin
            y.drv_en = 1'b0;
        end
        return y;
    endfunction

    function automatic axis_state_t f_rise(input axis_state_t x);
        axis_state_t y;
        y            = x;
        y.step_level = 1'b1;
        y.position   = x.dir_pos ? x.position + 32'd1 : x.position - 32'd1;
        return y;
    endfunction

    function automatic axis_state_t f_step(input axis_state_t x, input logic hold);
        axis_state_t y;
        logic [31:0] err;
        y   = x;
        err = x.goal_position - x.position;
        unique case (x.mode)
            MODE_TARGET: begin
                if (err == 32'd0) begin
                    y = f_stop(x, hold);
                end else if (x.step_level) begin
                    y.step_level = 1'b0;
                end else begin
                    y.dir_pos = !err[31];
                    y = f_rise(y);
                end
            end
            MODE_VEL: begin
                if (x.step_level) begin
                    y.step_level = 1'b0;
                end else begin
                    y.dir_pos = x.vel_pos;
                    y = f_rise(y);
                end
            end
            default: begin
                if (x.toggles_left == 33'd0) begin
                    y = f_stop(x, hold);
                end else begin
                    if (x.step_level) begin
                        y.step_level = 1'b0;
                    end else begin
                        y = f_rise(y);
                    end
                    y.toggles_left = y.toggles_left - 33'd1;
                    if (y.toggles_left == 33'd0) begin
                        y = f_stop(y, hold);
                    end
                end
            end
        endcase
        return y;
    endfunction

    function automatic axis_state_t f_tick(input axis_state_t x, input cfg_t c);
        axis_state_t y;
        y = x;
        if (x.moving) begin
            if (x.cur_hp == x.goal_hp) begin
                y.ramp_ticks = 4'd0;
            end else begin
                y.ramp_ticks = x.ramp_ticks + 4'd1;
                if (y.ramp_ticks >= c.ramp_interval) begin
                    y.ramp_ticks = 4'd0;
                    if (x.cur_hp > x.goal_hp) begin
                        y.cur_hp = x.cur_hp - 8'd1;
                    end else begin
                        y.cur_hp = x.cur_hp + 8'd1;
                    end
                end
            end
            y.ticks = x.ticks + 8'd1;
            if (y.ticks >= y.cur_hp) begin
                y.ticks = 8'd0;
                y = f_step(y, c.hold);
            end
        end
        return y;
    endfunction

    function automatic axis_state_t f_cont(input axis_state_t x, input logic starting,
                                           input logic want, input logic [7:0] s_hp);
        axis_state_t y;
        logic [7:0]  first_hp;
        logic        change;
        y        = x;
        first_hp = (x.goal_hp > s_hp) ? x.goal_hp : s_hp;
        change   = x.moving && (x.dir_pos != want);
        if (starting) begin
            y.toggles_left = 33'd0;
            y.cur_hp       = first_hp;
            y.ticks        = 8'd0;
            y.ramp_ticks   = 4'd0;
            y.step_level   = 1'b0;
        end else if (change) begin
            y.cur_hp     = first_hp;
            y.ramp_ticks = 4'd0;
        end
        if (!y.step_level) begin
            y.dir_pos = want;
        end
        y.moving = 1'b1;
        return y;
    endfunction

    assign mag       = amount[31] ? 32'd0 - amount : amount;
    assign vel_start = !cur.moving || (cur.mode != MODE_VEL);
    assign abs_start = !cur.moving || (cur.mode != MODE_TARGET);
    assign abs_pos   = $signed(amount) > $signed(cur.position);

    always_comb begin
        upd = cur;
        acc = 1'b1;
        unique case (cmd)
            CMD_TICK: begin
                upd = f_tick(cur, cfg);
            end
            CMD_REL: begin
                if (cur.moving) begin
                    acc = 1'b0;
                end else if (amount != 32'd0) begin
                    upd.dir_pos      = !amount[31];
                    upd.drv_en       = 1'b1;
                    upd.mode         = MODE_COUNT;
                    upd.toggles_left = {mag, 1'b0};
                    upd.step_level   = 1'b0;
                    upd.goal_hp      = hp_goal;
                    upd.cur_hp       = (hp_goal > hp_start) ? hp_goal : hp_start;
                    upd.ticks        = 8'd0;
                    upd.ramp_ticks   = 4'd0;
                    upd.moving       = 1'b1;
                end
            end
            CMD_VEL: begin
                if (amount == 32'd0) begin
                    upd = f_stop(cur, cfg.hold);
                end else begin
                    upd.drv_en  = 1'b1;
                    upd.mode    = MODE_VEL;
                    upd.vel_pos = !amount[31];
                    upd.goal_hp = hp_goal;
                    upd = f_cont(upd, vel_start, !amount[31], hp_start);
                end
            end
            CMD_ABS: begin
                upd.goal_position = amount;
                upd.goal_hp       = hp_goal;
                upd.mode          = MODE_TARGET;
                upd.drv_en        = 1'b1;
                if (amount == cur.position) begin
                    upd = f_stop(upd, cfg.hold);
                end else begin
                    upd = f_cont(upd, abs_start, abs_pos, hp_start);
                end
            end
            CMD_STOP: begin
                upd = f_stop(cur, cfg.hold);
            end
            CMD_ENABLE: begin
                upd.drv_en = (amount != 32'd0);
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    assign nxt = upd;

endmodule

@@ rtl/core/dual_stepper_pulse_generator.sv @@
// a tick passes both axes through the state memory, axis a and then axis b
// a move command runs two serial half period divisions, goal rate first, then start rate
// throughput: one command at a time, the next is taken once the result sits in the output stage
// unknown codes, stop and enable skip the divider; a result waiting on m_ready adds its stall
// reset: synchronous active low, restores the default limits and the idle state of both axes
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator
// step, direction and enable generation for two stepper axes with a linear ramp
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic               s_axis,
    input  logic signed [31:0] s_amount,
    input  logic [31:0]        s_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic               m_step_a,
    output logic               m_dir_a,
    output logic               m_enable_a,
    output logic               m_busy_a,
    output logic signed [31:0] m_position_a,
    output logic               m_step_b,
    output logic               m_dir_b,
    output logic               m_enable_b,
    output logic               m_busy_b,
    output logic signed [31:0] m_position_b,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data
);
    import dsp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DISPATCH,
        ST_DIV_GOAL,
        ST_DIV_START,
        ST_EXEC,
        ST_RESULT
    } state_t;

    state_t      state_reg;
    cfg_t        cfg_reg;
    logic [2:0]  cmd_reg;
    logic        axis_sel_reg;
    logic [31:0] amount_reg;
    logic [31:0] rate_reg;
    logic [7:0]  hp_goal_reg;
    logic [7:0]  hp_start_reg;
    logic        acc_reg;
    logic        m_valid_reg;
    logic        out_acc_reg;
    axis_view_t  mirror_reg [2];
    axis_view_t  out_reg [2];

    axis_state_t rd_data;
    axis_state_t upd_state;
    logic        upd_acc;
    logic        is_move;
    logic        div_start;
    logic        div_twice;
    logic [31:0] div_hz;
    logic [31:0] amount_mag;
    logic        div_done;
    logic [7:0]  div_hp;

    assign is_move    = (cmd_reg == CMD_REL) || (cmd_reg == CMD_VEL) || (cmd_reg == CMD_ABS);
    assign amount_mag = amount_reg[31] ? 32'd0 - amount_reg : amount_reg;
    assign div_start  = ((state_reg == ST_DISPATCH) && is_move)
                        || ((state_reg == ST_DIV_GOAL) && div_done);
    assign div_twice  = (state_reg == ST_DISPATCH) && (cmd_reg == CMD_VEL);

    always_comb begin
        if (state_reg == ST_DISPATCH) begin
            div_hz = (cmd_reg == CMD_VEL) ? amount_mag : rate_reg;
        end else begin
            div_hz = {20'd0, cfg_reg.start_rate};
        end
    end

    dsp_state_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (axis_sel_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_EXEC),
        .wr_addr (axis_sel_reg),
        .wr_data (upd_state)
    );

    dsp_half_period u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .hz      (div_hz),
        .twice   (div_twice),
        .cfg     (cfg_reg),
        .done    (div_done),
        .hp      (div_hp)
    );

    dsp_axis_update u_upd (
        .cmd      (cmd_reg),
        .amount   (amount_reg),
        .cfg      (cfg_reg),
        .hp_goal  (hp_goal_reg),
        .hp_start (hp_start_reg),
        .cur      (rd_data),
        .nxt      (upd_state),
        .acc      (upd_acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HOLD:  cfg_reg.hold          <= cfg_data[0];
                REG_MIN:   cfg_reg.min_rate      <= cfg_data;
                REG_MAX:   cfg_reg.max_rate      <= cfg_data;
                REG_START: cfg_reg.start_rate    <= cfg_data;
                REG_RAMP:  cfg_reg.ramp_interval <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            mirror_reg[0] <= VIEW_RESET;
            mirror_reg[1] <= VIEW_RESET;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_command;
                        axis_sel_reg <= (s_command == CMD_TICK) ? 1'b0 : s_axis;
                        amount_reg   <= s_amount;
                        rate_reg     <= s_rate;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_DISPATCH;
                end
                ST_DISPATCH: begin
                    state_reg <= is_move ? ST_DIV_GOAL : ST_EXEC;
                end
                ST_DIV_GOAL: begin
                    if (div_done) begin
                        hp_goal_reg <= div_hp;
                        state_reg   <= ST_DIV_START;
                    end
                end
                ST_DIV_START: begin
                    if (div_done) begin
                        hp_start_reg <= div_hp;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    mirror_reg[axis_sel_reg] <= '{
                        step: upd_state.step_level, dir: upd_state.dir_pos,
                        en: upd_state.drv_en, busy: upd_state.moving,
                        position: upd_state.position
                    };
                    acc_reg <= upd_acc;
                    // a tick visits axis b after axis a
                    if ((cmd_reg == CMD_TICK) && !axis_sel_reg) begin
                        axis_sel_reg <= 1'b1;
                        state_reg    <= ST_READ;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        out_acc_reg <= acc_reg;
                        out_reg[0]  <= mirror_reg[0];
                        out_reg[1]  <= mirror_reg[1];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_accepted   = out_acc_reg;
    assign m_step_a     = out_reg[0].step;
    assign m_dir_a      = out_reg[0].dir;
    assign m_enable_a   = out_reg[0].en;
    assign m_busy_a     = out_reg[0].busy;
    assign m_position_a = out_reg[0].position;
    assign m_step_b     = out_reg[1].step;
    assign m_dir_b      = out_reg[1].dir;
    assign m_enable_b   = out_reg[1].en;
    assign m_busy_b     = out_reg[1].busy;
    assign m_position_b = out_reg[1].position;

endmodule

@@ rtl/core/dsp_checker.sv @@
// ----------------------------------------------------------------------------
// dsp_checker
// port-level checks on the dual stepper pulse generator
// ----------------------------------------------------------------------------
`include "dual_stepper_pulse_generator_assert.svh"

module dsp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_accepted,
    input logic               m_step_a,
    input logic               m_busy_a,
    input logic signed [31:0] m_position_a,
    input logic               m_step_b,
    input logic               m_busy_b
);

    // one transaction in flight at a time
    `DSP_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a stalled result holds
    `DSP_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_position_a) && $stable(m_accepted))
    // a high step pin only while the axis moves
    `DSP_ASSERT_SAME(a_step_a_busy, aclk, aresetn, m_valid && m_step_a, m_busy_a)
    `DSP_ASSERT_SAME(a_step_b_busy, aclk, aresetn, m_valid && m_step_b, m_busy_b)
    // reset leaves the block idle and empty
    `DSP_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind dual_stepper_pulse_generator dsp_checker u_dsp_checker (.*);

@@ dv/dual_stepper_pulse_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_tb
// Drives directed then random commands through several limit settings and
// checks every result against a cycle-free model of both axes.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_tb;
    import dsp_pkg::*;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        ax;
        logic [31:0] amt;
        logic [31:0] rate;
    } cmd_item_t;

    typedef struct packed {
        logic        acc;
        logic [1:0]  step;
        logic [1:0]  dir;
        logic [1:0]  en;
        logic [1:0]  busy;
        logic [31:0] pos_a;
        logic [31:0] pos_b;
    } axes_view_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = '0;
    logic               s_axis = 1'b0;
    logic signed [31:0] s_amount = '0;
    logic [31:0]        s_rate = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_accepted, m_step_a, m_dir_a, m_enable_a, m_busy_a;
    logic               m_step_b, m_dir_b, m_enable_b, m_busy_b;
    logic signed [31:0] m_position_a, m_position_b;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [11:0]        cfg_data = '0;

    dual_stepper_pulse_generator u_top (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // model state
    cfg_t        lim;
    axis_state_t ax_st [2];

    cmd_item_t   cmd_q [$];
    axes_view_t  view_q [$];
    int          issue_cnt = 0;
    int          accept_cnt = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;

    function automatic logic [31:0] clamp_rate(input logic [31:0] hz);
        if (hz < lim.min_rate) return lim.min_rate;
        if (hz > lim.max_rate) return lim.max_rate;
        return hz;
    endfunction

    function automatic logic [7:0] hp_of(input logic [31:0] hz_in);
        logic [31:0] hz, d, hp;
        hz = clamp_rate(hz_in);
        if (hz == 0) return 8'd255;
        d = hz * 2;
        hp = (32'd10000 + d - 1) / d;
        if (hp == 0) hp = 1;
        if (hp > 255) hp = 255;
        return hp[7:0];
    endfunction

    function automatic logic [7:0] launch_hp(input logic [7:0] goal);
        logic [7:0] s;
        s = hp_of(lim.start_rate);
        return (goal > s) ? goal : s;
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic void halt(input int a);
        ax_st[a].toggles_left = '0;
        ax_st[a].step_level = 1'b0;
        ax_st[a].mode = MODE_COUNT;
        ax_st[a].moving = 1'b0;
        ax_st[a].ramp_ticks = '0;
        if (!lim.hold) ax_st[a].drv_en = 1'b0;
    endfunction

    function automatic void rise(input int a);
        ax_st[a].step_level = 1'b1;
        ax_st[a].position = ax_st[a].position + (ax_st[a].dir_pos ? 32'd1 : 32'hFFFF_FFFF);
    endfunction

    function automatic void half_period_done(input int a);
        logic [31:0] err;
        if (ax_st[a].mode == MODE_TARGET) begin
            err = ax_st[a].goal_position - ax_st[a].position;
            if (err == 0) begin
                halt(a);
            end else if (ax_st[a].step_level) begin
                ax_st[a].step_level = 1'b0;
            end else begin
                ax_st[a].dir_pos = !err[31];
                rise(a);
            end
        end else if (ax_st[a].mode == MODE_VEL) begin
            if (ax_st[a].step_level) begin
                ax_st[a].step_level = 1'b0;
            end else begin
                ax_st[a].dir_pos = ax_st[a].vel_pos;
                rise(a);
            end
        end else begin
            if (ax_st[a].toggles_left == 0) begin
                halt(a);
            end else begin
                if (ax_st[a].step_level) ax_st[a].step_level = 1'b0;
                else rise(a);
                ax_st[a].toggles_left = ax_st[a].toggles_left - 1;
                if (ax_st[a].toggles_left == 0) halt(a);
            end
        end
    endfunction

    function automatic void tick_axis(input int a);
        if (!ax_st[a].moving) return;
        if (ax_st[a].cur_hp == ax_st[a].goal_hp) begin
            ax_st[a].ramp_ticks = '0;
        end else begin
            ax_st[a].ramp_ticks = ax_st[a].ramp_ticks + 1;
            if (ax_st[a].ramp_ticks >= lim.ramp_interval) begin
                ax_st[a].ramp_ticks = '0;
                if (ax_st[a].cur_hp > ax_st[a].goal_hp) ax_st[a].cur_hp--;
                else ax_st[a].cur_hp++;
            end
        end
        ax_st[a].ticks = ax_st[a].ticks + 1;
        if (ax_st[a].ticks >= ax_st[a].cur_hp) begin
            ax_st[a].ticks = '0;
            half_period_done(a);
        end
    endfunction

    function automatic void resume_or_launch(input int a, input bit starting, input bit want);
        bit change;
        change = ax_st[a].moving && (ax_st[a].dir_pos != want);
        if (starting) begin
            ax_st[a].toggles_left = '0;
            ax_st[a].cur_hp = launch_hp(ax_st[a].goal_hp);
            ax_st[a].ticks = '0;
            ax_st[a].ramp_ticks = '0;
            ax_st[a].step_level = 1'b0;
        end else if (change) begin
            ax_st[a].cur_hp = launch_hp(ax_st[a].goal_hp);
            ax_st[a].ramp_ticks = '0;
        end
        if (!ax_st[a].step_level) ax_st[a].dir_pos = want;
        ax_st[a].moving = 1'b1;
    endfunction

    function automatic axes_view_t apply_command(input cmd_item_t it);
        axes_view_t v;
        int a;
        bit want, starting;
        a = it.ax;
        v.acc = 1'b1;
        case (it.cmd)
            CMD_TICK: begin
                tick_axis(0);
                tick_axis(1);
            end
            CMD_REL: begin
                if (ax_st[a].moving) begin
                    v.acc = 1'b0;
                end else if (it.amt != 0) begin
                    ax_st[a].dir_pos = !it.amt[31];
                    ax_st[a].drv_en = 1'b1;
                    ax_st[a].mode = MODE_COUNT;
                    ax_st[a].toggles_left = {1'b0, mag(it.amt)} << 1;
                    ax_st[a].step_level = 1'b0;
                    ax_st[a].goal_hp = hp_of(it.rate);
                    ax_st[a].cur_hp = launch_hp(ax_st[a].goal_hp);
                    ax_st[a].ticks = '0;
                    ax_st[a].ramp_ticks = '0;
                    ax_st[a].moving = 1'b1;
                end
            end
            CMD_VEL: begin
                if (it.amt == 0) begin
                    halt(a);
                end else begin
                    want = !it.amt[31];
                    starting = !ax_st[a].moving || ax_st[a].mode != MODE_VEL;
                    ax_st[a].drv_en = 1'b1;
                    ax_st[a].mode = MODE_VEL;
                    ax_st[a].vel_pos = want;
                    ax_st[a].goal_hp = hp_of(clamp_rate(mag(it.amt)));
                    resume_or_launch(a, starting, want);
                end
            end
            CMD_ABS: begin
                starting = !ax_st[a].moving || ax_st[a].mode != MODE_TARGET;
                want = $signed(it.amt) > $signed(ax_st[a].position);
                ax_st[a].goal_position = it.amt;
                ax_st[a].goal_hp = hp_of(it.rate);
                ax_st[a].mode = MODE_TARGET;
                ax_st[a].drv_en = 1'b1;
                if (it.amt == ax_st[a].position) halt(a);
                else resume_or_launch(a, starting, want);
            end
            CMD_STOP: halt(a);
            CMD_ENABLE: ax_st[a].drv_en = (it.amt != 0);
            default: v.acc = 1'b0;
        endcase
        v.step = {ax_st[1].step_level, ax_st[0].step_level};
        v.dir = {ax_st[1].dir_pos, ax_st[0].dir_pos};
        v.en = {ax_st[1].drv_en, ax_st[0].drv_en};
        v.busy = {ax_st[1].moving, ax_st[0].moving};
        v.pos_a = ax_st[0].position;
        v.pos_b = ax_st[1].position;
        return v;
    endfunction

    // command driver
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && issue_cnt != accept_cnt)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                s_valid <= 1'b1;
                s_command <= cmd_q[0].cmd;
                s_axis <= cmd_q[0].ax;
                s_amount <= cmd_q[0].amt;
                s_rate <= cmd_q[0].rate;
                issue_cnt <= issue_cnt + 1;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            view_q.push_back(apply_command(cmd_q[0]));
            void'(cmd_q.pop_front());
            accept_cnt <= accept_cnt + 1;
        end
    end

    // result side
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 13);
            end
        end
    end

    always @(posedge aclk) begin
        axes_view_t got, want_v;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_accepted, {m_step_b, m_step_a}, {m_dir_b, m_dir_a},
                    {m_enable_b, m_enable_a}, {m_busy_b, m_busy_a},
                    m_position_a, m_position_b};
            if (view_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, got);
                errors++;
            end else begin
                want_v = view_q.pop_front();
                if (got.acc !== want_v.acc) begin
                    $display("%0t: accepted exp %b got %b", $time, want_v.acc, got.acc);
                    errors++;
                end
                if (got.step !== want_v.step) begin
                    $display("%0t: step exp %b got %b", $time, want_v.step, got.step);
                    errors++;
                end
                if (got.dir !== want_v.dir) begin
                    $display("%0t: dir exp %b got %b", $time, want_v.dir, got.dir);
                    errors++;
                end
                if (got.en !== want_v.en) begin
                    $display("%0t: enable exp %b got %b", $time, want_v.en, got.en);
                    errors++;
                end
                if (got.busy !== want_v.busy) begin
                    $display("%0t: busy exp %b got %b", $time, want_v.busy, got.busy);
                    errors++;
                end
                if (got.pos_a !== want_v.pos_a) begin
                    $display("%0t: position_a exp %0d got %0d", $time,
                             $signed(want_v.pos_a), $signed(got.pos_a));
                    errors++;
                end
                if (got.pos_b !== want_v.pos_b) begin
                    $display("%0t: position_b exp %0d got %0d", $time,
                             $signed(want_v.pos_b), $signed(got.pos_b));
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HOLD:  lim.hold = val[0];
            REG_MIN:   lim.min_rate = val;
            REG_MAX:   lim.max_rate = val;
            REG_START: lim.start_rate = val;
            REG_RAMP:  lim.ramp_interval = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic hold, input logic [11:0] lo, input logic [11:0] hi,
                              input logic [11:0] st, input logic [3:0] rmp);
        write_reg(REG_HOLD, {11'd0, hold});
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
        write_reg(REG_START, st);
        write_reg(REG_RAMP, {8'd0, rmp});
    endtask

    task automatic wait_drained();
        while (cmd_q.size() > 0 || view_q.size() > 0 || s_valid) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic cmd_item_t make_cmd(input logic [2:0] c, input logic a,
                                           input logic [31:0] amt, input logic [31:0] r);
        return '{c, a, amt, r};
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t it;
        int sel;
        it.ax = $urandom_range(0, 1);
        it.rate = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 4500);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            it.cmd = CMD_TICK;
            it.amt = $urandom;
        end else if (sel < 68) begin
            it.cmd = CMD_REL;
            it.amt = $urandom_range(1, 6);
            if ($urandom_range(0, 1)) it.amt = -it.amt;
            if ($urandom_range(0, 19) == 0) it.amt = $urandom;
        end else if (sel < 76) begin
            it.cmd = CMD_VEL;
            it.amt = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
            if ($urandom_range(0, 1)) it.amt = -it.amt;
        end else if (sel < 86) begin
            it.cmd = CMD_ABS;
            it.amt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40) - 20;
        end else if (sel < 92) begin
            it.cmd = CMD_STOP;
            it.amt = $urandom;
        end else if (sel < 97) begin
            it.cmd = CMD_ENABLE;
            it.amt = $urandom_range(0, 1) ? 32'd0 : $urandom;
        end else begin
            it.cmd = $urandom_range(6, 7);
            it.amt = $urandom;
        end
        return it;
    endfunction

    task automatic random_burst(input int n);
        repeat (n) cmd_q.push_back(random_cmd());
        wait_drained();
    endtask

    initial begin
        lim = CFG_RESET;
        ax_st[0] = AXIS_RESET;
        ax_st[1] = AXIS_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, refusals and edge cases
        cmd_q.push_back(make_cmd(CMD_TICK, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_q.push_back(make_cmd(CMD_REL, 1'b0, 32'd0, 32'd100));
        cmd_q.push_back(make_cmd(CMD_REL, 1'b0, 32'd2, 32'd4000));
        cmd_q.push_back(make_cmd(CMD_REL, 1'b0, 32'd3, 32'd100));
        repeat (6) cmd_q.push_back(make_cmd(CMD_TICK, 1'b0, 32'd0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_REL, 1'b1, 32'h8000_0000, 32'd0));
        repeat (3) cmd_q.push_back(make_cmd(CMD_TICK, 1'b0, 32'd0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_STOP, 1'b1, 32'd0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_VEL, 1'b1, 32'h8000_0000, 32'd0));
        cmd_q.push_back(make_cmd(CMD_VEL, 1'b1, 32'h7FFF_FFFF, 32'd0));
        cmd_q.push_back(make_cmd(CMD_VEL, 1'b1, 32'd0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_ABS, 1'b0, 32'd0, 32'd500));
        cmd_q.push_back(make_cmd(CMD_ABS, 1'b0, 32'h8000_0001, 32'd500));
        cmd_q.push_back(make_cmd(CMD_ABS, 1'b0, 32'h7FFF_FFFF, 32'd500));
        cmd_q.push_back(make_cmd(CMD_ENABLE, 1'b0, 32'd0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_ENABLE, 1'b1, 32'h8000_0000, 32'd0));
        cmd_q.push_back(make_cmd(3'd6, 1'b0, 32'd1, 32'd1));
        cmd_q.push_back(make_cmd(3'd7, 1'b1, 32'd1, 32'd1));
        cmd_q.push_back(make_cmd(CMD_STOP, 1'b0, 32'd0, 32'd0));
        wait_drained();

        random_burst(70);
        set_limits(1'b0, 12'd20, 12'd4000, 12'd4000, 4'd1);
        random_burst(70);
        // inverted limits, start rate of 20, longest ramp step
        set_limits(1'b1, 12'd4000, 12'd20, 12'd20, 4'd15);
        random_burst(60);
        // zero limits and zero ramp interval
        set_limits(1'b0, 12'd0, 12'd0, 12'd0, 4'd0);
        random_burst(60);
        set_limits(1'b1, 12'd4095, 12'd4095, 12'd4095, 4'd3);
        random_burst(40);
        set_limits(1'b1, 12'd20, 12'd4000, 12'd300, 4'd8);
        random_burst(40);
        quiet = 1'b1;
        random_burst(60);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
